// ----- rtl/core/upd_pkg.sv -----
// shared types and constants of the url percent decoder
package upd_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // characters the decoder reacts to
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_U_LOWER = 8'h75;
    localparam logic [7:0] CH_U_UPPER = 8'h55;

    // the results caused by one input word: data bytes first, then the status
    typedef struct packed {
        logic [1:0]      n_data;
        logic            status;
        logic            ok;
        logic [2:0][7:0] bytes;
    } upd_bundle_t;

endpackage

// ----- rtl/core/url_percent_decoder_utf8_top.sv -----
// top level of the url percent decoder with utf-8 output
// Decodes url-encoded text one byte per word: '+' gives a space, "%hh" one byte,
// "%u0hhhh" one to three utf-8 bytes (surrogates give nothing), and the word with
// tlast set ends with one status word whose tuser[1] tells ok (1) or error (0).
// The input side takes one word per clock as long as the bundle queue
// (QUEUE_DEPTH entries) has room; the output side gives one word per clock from
// its register while m_tready is high. Each input word causes zero to four output
// words, so the sustained input rate is one word per clock where each word yields
// at most one result, and otherwise is set by the output port at one result per
// clock. With the queue empty and the output register free, m_tvalid for the first
// result of a word rises at the clock edge after the one that accepts the word.
module url_percent_decoder_utf8_top #(
    parameter int QUEUE_DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic       s_tuser,   // byte_present
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // is_status, decode_ok
    output logic       m_tlast    // last_of_run
);
    import upd_pkg::*;

    upd_bundle_t push_data, head;
    logic        push, pop, full, empty;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (full),
        .push      (push),
        .push_data (push_data)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    upd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule

// ----- rtl/core/upd_front.sv -----
// front part: accepts text words, runs the escape parser, builds result bundles
module upd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // text_byte
    input  logic                s_tuser,   // byte_present
    input  logic                s_tlast,   // end_of_text
    input  logic                q_full,
    output logic                push,
    output upd_pkg::upd_bundle_t push_data
);
    import upd_pkg::*;

    typedef enum logic [4:0] {
        PH_PLAIN = 5'b00001,
        PH_PCT   = 5'b00010,
        PH_ZERO  = 5'b00100,
        PH_UHEX  = 5'b01000,
        PH_HEX2  = 5'b10000
    } phase_t;

    // returns {valid, value} for one ascii hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  digits_reg, digits_next;
    logic [11:0] code_reg, code_next;
    logic        err_reg, err_next;

    logic        accept;
    logic [4:0]  hex;
    logic [15:0] cp;
    upd_bundle_t bnd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign hex      = hex_digit(s_tdata);
    assign cp       = {code_reg, hex[3:0]};

    // parser step and status generation
    always_comb
    begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        code_next   = code_reg;
        err_next    = err_reg;
        bnd         = '0;
        if (accept && s_tuser && !err_reg)
        begin
            unique case (phase_reg)
                PH_PCT:
                begin
                    if (s_tdata == CH_U_LOWER || s_tdata == CH_U_UPPER)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (hex[4])
                    begin
                        code_next  = {8'b0, hex[3:0]};
                        phase_next = PH_HEX2;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (s_tdata == CH_ZERO)
                    begin
                        phase_next  = PH_UHEX;
                        digits_next = 2'd0;
                        code_next   = '0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_UHEX:
                begin
                    if (!hex[4])
                    begin
                        err_next = 1'b1;
                    end
                    else if (digits_reg == 2'd3)
                    begin
                        // fourth digit: encode the code point as utf-8
                        phase_next  = PH_PLAIN;
                        digits_next = 2'd0;
                        code_next   = '0;
                        if (cp < 16'h0080)
                        begin
                            bnd.n_data   = 2'd1;
                            bnd.bytes[0] = cp[7:0];
                        end
                        else if (cp < 16'h0800)
                        begin
                            bnd.n_data   = 2'd2;
                            bnd.bytes[0] = {3'b110, cp[10:6]};
                            bnd.bytes[1] = {2'b10, cp[5:0]};
                        end
                        else if (cp[15:11] != 5'b11011)
                        begin
                            bnd.n_data   = 2'd3;
                            bnd.bytes[0] = {4'b1110, cp[15:12]};
                            bnd.bytes[1] = {2'b10, cp[11:6]};
                            bnd.bytes[2] = {2'b10, cp[5:0]};
                        end
                    end
                    else
                    begin
                        code_next   = cp[11:0];
                        digits_next = digits_reg + 2'd1;
                    end
                end
                PH_HEX2:
                begin
                    if (hex[4])
                    begin
                        bnd.n_data   = 2'd1;
                        bnd.bytes[0] = {code_reg[3:0], hex[3:0]};
                        phase_next   = PH_PLAIN;
                        code_next    = '0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    if (s_tdata == CH_PERCENT)
                    begin
                        phase_next = PH_PCT;
                    end
                    else if (s_tdata == CH_PLUS)
                    begin
                        bnd.n_data   = 2'd1;
                        bnd.bytes[0] = CH_SPACE;
                    end
                    else
                    begin
                        bnd.n_data   = 2'd1;
                        bnd.bytes[0] = s_tdata;
                    end
                end
            endcase
        end
        // end of text: append status, start a new text
        if (accept && s_tlast)
        begin
            bnd.status  = 1'b1;
            bnd.ok      = !err_next && (phase_next == PH_PLAIN);
            phase_next  = PH_PLAIN;
            digits_next = 2'd0;
            code_next   = '0;
            err_next    = 1'b0;
        end
    end

    assign push      = accept && (bnd.n_data != 2'd0 || bnd.status);
    assign push_data = bnd;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            digits_reg <= 2'd0;
            code_reg   <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            code_reg   <= code_next;
            err_reg    <= err_next;
        end
    end

`ifndef ASSERT_OFF
    a_text_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PH_PLAIN && !err_reg && digits_reg == 2'd0)
        else $error("parser state not cleared after end of text");
    a_no_empty_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_data.n_data != 2'd0 || push_data.status)
        else $error("empty bundle pushed");
    a_no_data_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> push_data.n_data == 2'd0)
        else $error("data produced after an error");
`endif
endmodule

// ----- rtl/core/upd_queue.sv -----
// short bundle queue between the front and back parts
module upd_queue #(
    parameter int DEPTH = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  upd_pkg::upd_bundle_t push_data,
    input  logic                 pop,
    output upd_pkg::upd_bundle_t head,
    output logic                 full,
    output logic                 empty
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_bundle_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif
endmodule

// ----- rtl/core/upd_back.sv -----
// back part: unpacks bundles into output words through an output register
module upd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  upd_pkg::upd_bundle_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_byte
    output logic [1:0]           m_tuser,   // is_status, decode_ok
    output logic                 m_tlast    // last_of_run
);
    import upd_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] user_reg;
    logic       last_reg;

    logic       load;
    logic [2:0] total;
    logic       is_data;
    logic       is_last;
    logic [7:0] sel_byte;
    logic [1:0] sel_user;

    // pick the current element of the head bundle
    assign load     = !valid_reg || m_tready;
    assign total    = {1'b0, head.n_data} + {2'b0, head.status};
    assign is_data  = idx_reg < head.n_data;
    assign is_last  = ({1'b0, idx_reg} == total - 3'd1);
    assign sel_byte = is_data ? head.bytes[idx_reg] : 8'h00;
    assign sel_user = is_data ? 2'b00 : {head.ok, 1'b1};
    assign pop      = load && !empty && is_last;

    // output register and element index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
            begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            byte_reg <= sel_byte;
            user_reg <= sel_user;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> {1'b0, idx_reg} < total)
        else $error("element index beyond bundle");
`endif
endmodule

// ----- verif/url_decode_checker.sv -----
// scoreboard for the url percent decoder: predicts every decoded word and compares
module url_decode_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,      // text_byte
    input  logic       s_tuser,      // byte_present
    input  logic       s_tlast,      // end_of_text
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,      // out_byte
    input  logic [1:0] m_tuser,      // is_status, decode_ok
    input  logic       m_tlast,      // last_of_run
    output int         fail_count,
    output int         pending,
    output int         words_in,
    output int         words_out,
    output int         texts_clean,
    output int         texts_broken
);
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_A_LO = "a";
    localparam logic [7:0] CH_F_LO = "f";
    localparam logic [7:0] CH_A_UP = "A";
    localparam logic [7:0] CH_F_UP = "F";

    // where the decoder stands inside an escape
    typedef enum logic [2:0] {
        ESC_NONE,
        ESC_PERCENT,
        ESC_WANT_ZERO,
        ESC_CODE_POINT,
        ESC_LOW_NIBBLE
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       decode_ok;
        logic       last_of_run;
    } decoded_word_t;

    esc_phase_t    esc_phase;
    logic [2:0]    nibbles_read;
    logic [15:0]   code_acc;
    logic          text_failed;

    decoded_word_t pending_decodes[$];
    decoded_word_t run_words[$];
    decoded_word_t want;
    decoded_word_t status_word;
    int            mismatches;
    int            n_in;
    int            n_out;
    int            n_clean;
    int            n_broken;

    // hex digit value, -1 when the byte is not a hex digit
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_A_LO && c <= CH_F_LO)
            return int'(c - CH_A_LO) + 10;
        if (c >= CH_A_UP && c <= CH_F_UP)
            return int'(c - CH_A_UP) + 10;
        return -1;
    endfunction

    function automatic void clear_text_state();
        esc_phase    = ESC_NONE;
        nibbles_read = 3'd0;
        code_acc     = 16'h0000;
        text_failed  = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] b);
        decoded_word_t w;
        w = '{b, 1'b0, 1'b0, 1'b0};
        run_words.insert(run_words.size(), w);
    endfunction

    // one text byte through the escape machine
    function automatic void decode_byte(input logic [7:0] c);
        int          nib;
        logic [15:0] cp;
        if (text_failed)
            return;
        nib = nibble_of(c);
        case (esc_phase)
            ESC_PERCENT:
            begin
                if (c == CH_U_LOWER || c == CH_U_UPPER)
                    esc_phase = ESC_WANT_ZERO;
                else if (nib < 0)
                    text_failed = 1'b1;
                else
                begin
                    code_acc  = 16'(nib);
                    esc_phase = ESC_LOW_NIBBLE;
                end
            end
            ESC_WANT_ZERO:
            begin
                if (c != CH_ZERO)
                    text_failed = 1'b1;
                else
                begin
                    esc_phase    = ESC_CODE_POINT;
                    nibbles_read = 3'd0;
                    code_acc     = 16'h0000;
                end
            end
            ESC_CODE_POINT:
            begin
                if (nib < 0)
                    text_failed = 1'b1;
                else
                begin
                    cp           = {code_acc[11:0], 4'(nib)};
                    code_acc     = cp;
                    nibbles_read = nibbles_read + 3'd1;
                    if (nibbles_read >= 3'd4)
                    begin
                        // utf-8 encoding, surrogate halves give nothing
                        if (cp < 16'h0080)
                            emit(cp[7:0]);
                        else if (cp < 16'h0800)
                        begin
                            emit({3'b110, cp[10:6]});
                            emit({2'b10, cp[5:0]});
                        end
                        else if (cp[15:11] != 5'b11011)
                        begin
                            emit({4'b1110, cp[15:12]});
                            emit({2'b10, cp[11:6]});
                            emit({2'b10, cp[5:0]});
                        end
                        esc_phase    = ESC_NONE;
                        nibbles_read = 3'd0;
                        code_acc     = 16'h0000;
                    end
                end
            end
            ESC_LOW_NIBBLE:
            begin
                if (nib < 0)
                    text_failed = 1'b1;
                else
                begin
                    emit({code_acc[3:0], 4'(nib)});
                    esc_phase = ESC_NONE;
                    code_acc  = 16'h0000;
                end
            end
            default:
            begin
                if (c == CH_PERCENT)
                    esc_phase = ESC_PERCENT;
                else if (c == CH_PLUS)
                    emit(CH_SPACE);
                else
                    emit(c);
            end
        endcase
    endfunction

    // predict on accepted input words, compare on accepted output words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text_state();
            pending_decodes.delete();
            mismatches   = 0;
            n_in         = 0;
            n_out        = 0;
            n_clean      = 0;
            n_broken     = 0;
            fail_count   <= 0;
            pending      <= 0;
            words_in     <= 0;
            words_out    <= 0;
            texts_clean  <= 0;
            texts_broken <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                n_in++;
                run_words.delete();
                if (s_tuser)
                    decode_byte(s_tdata);
                if (s_tlast)
                begin
                    status_word = '{8'h00, 1'b1,
                                    !text_failed && esc_phase == ESC_NONE, 1'b0};
                    run_words.insert(run_words.size(), status_word);
                    clear_text_state();
                end
                if (run_words.size() > 0)
                    run_words[run_words.size() - 1].last_of_run = 1'b1;
                foreach (run_words[i])
                    pending_decodes.insert(pending_decodes.size(), run_words[i]);
            end

            if (m_tvalid && m_tready)
            begin
                n_out++;
                if (pending_decodes.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h, tuser %b, tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = pending_decodes.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.is_status)
                    begin
                        $error("is_status mismatch: expected %b, actual %b",
                               want.is_status, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.decode_ok)
                    begin
                        $error("decode_ok mismatch: expected %b, actual %b",
                               want.decode_ok, m_tuser[1]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last_of_run)
                    begin
                        $error("last_of_run mismatch: expected %b, actual %b",
                               want.last_of_run, m_tlast);
                        mismatches++;
                    end
                    if (want.is_status && want.decode_ok)
                        n_clean++;
                    else if (want.is_status)
                        n_broken++;
                end
            end

            fail_count   <= mismatches;
            pending      <= pending_decodes.size();
            words_in     <= n_in;
            words_out    <= n_out;
            texts_clean  <= n_clean;
            texts_broken <= n_broken;
        end
    end

endmodule

// ----- verif/url_percent_decoder_utf8_top_tb.sv -----
// testbench top for the url percent decoder: stimulus, flow control and verdict
module url_percent_decoder_utf8_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL    = 40;
    localparam int LONG_HOLD    = 250;

    localparam logic [7:0] CH_A_LO = "a";
    localparam logic [7:0] CH_A_UP = "A";

    typedef struct {
        logic [7:0] ch;
        logic       present;
        logic       last;
    } text_item_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // text_byte
    logic       s_tuser  = 1'b0;   // byte_present
    logic       s_tlast  = 1'b0;   // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // out_byte
    logic [1:0] m_tuser;           // is_status, decode_ok
    logic       m_tlast;           // last_of_run

    int fail_count;
    int pending;
    int words_in;
    int words_out;
    int texts_clean;
    int texts_broken;

    text_item_t text_q[$];
    int         items_sent  = 0;
    int         cycle_count = 0;
    logic       src_idle    = 1'b1;
    logic       sink_idle   = 1'b1;
    logic       hold_req    = 1'b0;
    logic       hold_taken  = 1'b0;

    url_percent_decoder_utf8_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    url_decode_checker u_decode_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_in     (words_in),
        .words_out    (words_out),
        .texts_clean  (texts_clean),
        .texts_broken (texts_broken)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // hex digit in random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(v - 4'd10);
    endfunction

    // byte that is neither a hex digit nor the unicode selector
    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
               || c == CH_U_LOWER || c == CH_U_UPPER);
        return c;
    endfunction

    function automatic logic [7:0] u_char();
        return $urandom_range(0, 1) ? CH_U_UPPER : CH_U_LOWER;
    endfunction

    task automatic push_item(input logic [7:0] c, input logic present = 1'b1,
                             input logic last = 1'b0);
        text_item_t it;
        it = '{c, present, last};
        text_q.insert(text_q.size(), it);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i]);
    endtask

    // well-formed pieces of text
    task automatic add_good();
        logic [7:0]  c;
        logic [15:0] cp;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            do
                c = 8'($urandom);
            while (c == CH_PERCENT);
            push_item(c);
        end
        else if (pick < 38)
            push_item(CH_PLUS);
        else if (pick < 60)
        begin
            push_item(CH_PERCENT);
            push_item(hex_char(4'($urandom)));
            push_item(hex_char(4'($urandom)));
        end
        else if (pick < 90)
        begin
            // one, two or three utf-8 bytes, or a surrogate
            case ($urandom_range(0, 3))
                0:       cp = 16'($urandom_range(0, 'h7f));
                1:       cp = 16'($urandom_range('h80, 'h7ff));
                2:       cp = 16'($urandom_range('hd800, 'hdfff));
                default: cp = 16'($urandom_range('h800, 'hffff));
            endcase
            push_item(CH_PERCENT);
            push_item(u_char());
            push_item(CH_ZERO);
            for (int k = 3; k >= 0; k--)
                push_item(hex_char(cp[4*k +: 4]));
        end
        else
            push_item(8'($urandom), 1'b0);
    endtask

    // broken escapes; at the end of a text the escape is just cut short
    task automatic add_broken(input bit at_end);
        logic [7:0] c;
        push_item(CH_PERCENT);
        if (at_end)
        begin
            case ($urandom_range(0, 3))
                0:       ;
                1:       push_item(hex_char(4'($urandom)));
                2:       push_item(u_char());
                default:
                begin
                    push_item(u_char());
                    push_item(CH_ZERO);
                    repeat ($urandom_range(0, 3))
                        push_item(hex_char(4'($urandom)));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       push_item(non_hex_char());
                1:
                begin
                    push_item(hex_char(4'($urandom)));
                    push_item(non_hex_char());
                end
                2:
                begin
                    // anything but the '0' after the selector
                    push_item(u_char());
                    do
                        c = 8'($urandom);
                    while (c == CH_ZERO);
                    push_item(c);
                end
                default:
                begin
                    push_item(u_char());
                    push_item(CH_ZERO);
                    repeat ($urandom_range(0, 3))
                        push_item(hex_char(4'($urandom)));
                    push_item(non_hex_char());
                end
            endcase
        end
    endtask

    // mark the end of the text and send every word of it
    task automatic close_and_send(input bit empty_final);
        text_item_t it;
        if (empty_final || text_q.size() == 0)
            push_item(8'($urandom), 1'b0, 1'b1);
        else
            text_q[text_q.size() - 1].last = 1'b1;
        while (text_q.size() > 0)
        begin
            it = text_q.pop_front();
            if (src_idle && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.ch;
            s_tuser  <= it.present;
            s_tlast  <= it.last;
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            items_sent++;
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD)
                    @(posedge clk);
            end
            else if (sink_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int   random_start;
        int   ntok;
        int   broken_at;
        logic pressure_done;
        pressure_done = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // byte extremes, plus, hex escape, empty word, surrogate, empty final word
        push_item(8'h00);
        push_item(8'hff);
        push_str("+%aF");
        push_item(8'($urandom), 1'b0);
        push_str("%u0d800");
        close_and_send(1'b1);
        // three-byte code point finishing on the final word: four results
        push_str("%U0FFFF");
        close_and_send(1'b0);
        // missing zero after the selector, then bytes swallowed after the error
        push_str("%uxz");
        close_and_send(1'b1);
        // escape still open at the end
        push_str("%4");
        close_and_send(1'b0);

        // random texts, mostly well formed
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (!pressure_done && items_sent - random_start > RANDOM_ITEMS / 3)
            begin
                pressure_done = 1'b1;
                hold_req  <= 1'b1;
                sink_idle <= 1'b0;
                src_idle  = 1'b0;
            end
            else if (items_sent - random_start > RANDOM_ITEMS - CALM_TAIL)
            begin
                sink_idle <= 1'b0;
                src_idle  = 1'b0;
            end
            else
            begin
                sink_idle <= ($urandom_range(0, 3) != 0);
                src_idle  = ($urandom_range(0, 3) != 0);
            end
            ntok      = $urandom_range(1, 8);
            broken_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ntok) : -1;
            for (int i = 0; i < ntok; i++)
            begin
                if (i == broken_at)
                    add_broken(1'b0);
                else
                    add_good();
            end
            if (broken_at == ntok)
                add_broken(1'b1);
            close_and_send($urandom_range(0, 2) == 0);
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);

        $display("summary: %0d text words in, %0d decoded words out", words_in, words_out);
        $display("summary: %0d texts clean, %0d texts with errors, one %0d-cycle output hold",
                 texts_clean, texts_broken, LONG_HOLD);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
